// ----- src/ped_pkg.sv -----
// Package for the percent codec: item and job types, mode codes, character helpers.
// No dependencies; imported by every module of the codec.
`default_nettype none

package ped_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [1:0] MODE_ENC_KEEP = 2'd0;
    localparam logic [1:0] MODE_ENC_COMP = 2'd1;
    localparam logic [1:0] MODE_DECODE   = 2'd2;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_SLASH   = 8'h2f;
    localparam logic [7:0] HEX_TEN      = 8'h0a;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       decode_error;
        logic       run_last;
        logic       string_done;
    } t_out_item;

    // One queued job: either a single result or a three-result escape of out_byte.
    typedef struct packed {
        logic       esc;
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       decode_error;
        logic       done;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_head;

    function automatic logic is_kept(input logic [7:0] c, input logic keep_slash);
        logic r;
        r = 1'b0;
        if ((c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
            (c >= 8'h30 && c <= 8'h39)) begin
            r = 1'b1;
        end
        if (c == 8'h21 || (c >= 8'h27 && c <= 8'h2a) || c == 8'h2d || c == 8'h2e ||
            c == 8'h5f || c == 8'h7e) begin
            r = 1'b1;
        end
        if (keep_slash && c == CHAR_SLASH) begin
            r = 1'b1;
        end
        return r;
    endfunction

    // Bit 4 set: not an uppercase hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        logic [7:0] d;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            r = {1'b0, d[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = HEX_TEN + (c - 8'h41);
            r = {1'b0, d[3:0]};
        end
        return r;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] w;
        w = {4'h0, v};
        return (w < HEX_TEN) ? (8'h30 + w) : (8'h41 + (w - HEX_TEN));
    endfunction

endpackage

`default_nettype wire

// ----- src/ped_front.sv -----
// Front end: mode register, decode state, classifies each input transfer into a job.
// Depends on ped_pkg.
`default_nettype none

module ped_front
    import ped_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    input  wire logic [1:0] i_cfg_data,
    input  wire logic       i_valid,
    input  wire t_in_item   i_data,
    input  wire logic       i_full,
    output logic            o_push,
    output t_job            o_job
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    logic [1:0] r_mode, n_mode;
    logic [1:0] r_phase, n_phase;
    logic [3:0] r_nib, n_nib;
    logic       r_drop, n_drop;
    logic       accept;
    logic       produced;
    logic [4:0] hv;
    logic [7:0] c;

    assign accept = i_valid && !i_full && !i_cfg_valid;
    assign c      = i_data.in_byte;
    assign hv     = hex_value(c);

    always_comb begin
        n_mode   = r_mode;
        n_phase  = r_phase;
        n_nib    = r_nib;
        n_drop   = r_drop;
        produced = 1'b0;
        o_job    = '0;
        if (i_cfg_valid) begin
            n_mode  = i_cfg_data;
            n_phase = PH_IDLE;
            n_nib   = 4'h0;
            n_drop  = 1'b0;
        end else if (accept) begin
            if (!r_mode[1]) begin
                produced         = 1'b1;
                o_job.esc        = !is_kept(c, r_mode == MODE_ENC_KEEP);
                o_job.out_byte   = c;
                o_job.byte_valid = 1'b1;
            end else if (!r_drop) begin
                case (r_phase)
                    PH_IDLE: begin
                        if (c == CHAR_PERCENT) begin
                            n_phase = PH_HIGH;
                        end else begin
                            produced         = 1'b1;
                            o_job.out_byte   = c;
                            o_job.byte_valid = 1'b1;
                        end
                    end
                    PH_HIGH: begin
                        if (!hv[4]) begin
                            n_nib   = hv[3:0];
                            n_phase = PH_LOW;
                        end else begin
                            produced           = 1'b1;
                            o_job.decode_error = 1'b1;
                            n_phase            = PH_IDLE;
                            n_nib              = 4'h0;
                            n_drop             = 1'b1;
                        end
                    end
                    default: begin
                        produced = 1'b1;
                        if (!hv[4]) begin
                            o_job.out_byte   = {r_nib, hv[3:0]};
                            o_job.byte_valid = 1'b1;
                        end else begin
                            o_job.decode_error = 1'b1;
                            n_drop             = 1'b1;
                        end
                        n_phase = PH_IDLE;
                        n_nib   = 4'h0;
                    end
                endcase
            end
            if (i_data.string_end) begin
                o_job.done = 1'b1;
                n_phase    = PH_IDLE;
                n_nib      = 4'h0;
                n_drop     = 1'b0;
            end
        end
    end

    assign o_push = accept && (produced || i_data.string_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_ENC_KEEP;
            r_phase <= PH_IDLE;
            r_nib   <= 4'h0;
            r_drop  <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_nib   <= n_nib;
            r_drop  <= n_drop;
        end
    end

endmodule

`default_nettype wire

// ----- src/ped_queue.sv -----
// Short job queue between front and back end, register based.
// Depends on ped_pkg.
`default_nettype none

module ped_queue
    import ped_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output logic      o_full,
    output t_head     o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_pop;

    assign do_pop        = i_pop && (r_count != '0);
    assign o_full        = (r_count == CNT_FULL);
    assign o_head.valid  = (r_count != '0);
    assign o_head.job    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

// ----- src/ped_back.sv -----
// Back end: expands the head job into results, one per cycle while not stalled, into the output register.
// Depends on ped_pkg.
`default_nettype none

module ped_back
    import ped_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_head i_head,
    input  wire logic i_stall,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_item o_data
);

    localparam logic [1:0] STEP_PCT = 2'd0;
    localparam logic [1:0] STEP_HI  = 2'd1;
    localparam logic [1:0] STEP_LO  = 2'd2;

    logic [1:0] r_step, n_step;
    logic       r_valid;
    t_out_item  r_data;
    t_out_item  res;
    logic       load;
    logic       last;

    assign load  = i_head.valid && (!r_valid || !i_stall);
    assign last  = !i_head.job.esc || (r_step == STEP_LO);
    assign o_pop = load && last;

    always_comb begin
        res              = '0;
        res.byte_valid   = i_head.job.byte_valid;
        res.decode_error = i_head.job.decode_error;
        res.run_last     = last;
        res.string_done  = last && i_head.job.done;
        if (i_head.job.esc) begin
            case (r_step)
                STEP_PCT: res.out_byte = CHAR_PERCENT;
                STEP_HI:  res.out_byte = hex_digit(i_head.job.out_byte[7:4]);
                default:  res.out_byte = hex_digit(i_head.job.out_byte[3:0]);
            endcase
        end else begin
            res.out_byte = i_head.job.out_byte;
        end
        n_step = r_step;
        if (load) begin
            n_step = last ? STEP_PCT : r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= STEP_PCT;
        end else begin
            r_step <= n_step;
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- src/percent_encode_decode_core.sv -----
// Top level of the URL percent codec: front end, job queue, back end.
// Depends on ped_pkg, ped_front, ped_queue, ped_back.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------
//  input    | in        | i_valid / o_stall         | i_data (t_in_item)
//  output   | out       | o_valid / i_stall         | o_data (t_out_item)
//  config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (mode code)
//
// One input transfer per cycle while the queue has room and i_cfg_valid is low.
// Escaped encode bytes give three results, every other item one (or none when silent).
// Sustained rate is set by the back end: one result per cycle while not stalled.
// With an empty queue, an input is registered in the queue, then in the output register.
// Synchronous active-low reset clears mode, decode state, queue and output valid.
// Output stalls back up through the queue to o_stall once it holds QDEPTH jobs.
`default_nettype none

module percent_encode_decode_core
    import ped_pkg::*;
#(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire t_in_item   i_data,
    output logic            o_valid,
    input  wire logic       i_stall,
    output t_out_item       o_data
);

    logic  push;
    logic  pop;
    logic  full;
    t_job  job;
    t_head head;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = full || i_cfg_valid;

    ped_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .i_full      (full),
        .o_push      (push),
        .o_job       (job)
    );

    ped_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    ped_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_stall (i_stall),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

`default_nettype wire

// ----- src/ped_checker.sv -----
// Port-level checks for the percent codec top level, bound to it below.
// Depends on ped_pkg and percent_encode_decode_core.
`default_nettype none

module ped_checker
    import ped_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_cfg_valid,
    input wire logic       o_cfg_ready,
    input wire logic [1:0] i_cfg_data,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire t_in_item   i_data,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire t_out_item  o_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("output transfer changed while stalled");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.string_done) |-> o_data.run_last)
        else $error("string end not on last result of its input");

    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.decode_error) |->
            (!o_data.byte_valid && o_data.out_byte == 8'h00))
        else $error("error result carries a byte");

    a_empty_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.byte_valid) |->
            (o_data.run_last && o_data.out_byte == 8'h00))
        else $error("byteless result not alone or not zero");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind percent_encode_decode_core ped_checker u_ped_checker (.*);

`default_nettype wire
